// ===== rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the 3D LUT interpolator RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/lti_pkg.sv =====
// -----------------------------------------------------------------------------
// lti_pkg
// Request, response and lattice entry types plus register codes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lti_pkg;

   typedef struct packed {
      logic              operation;
      logic [15:0]       entry_index;
      logic signed [31:0] red_in;
      logic signed [31:0] green_in;
      logic signed [31:0] blue_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] red_out;
      logic signed [31:0] green_out;
      logic signed [31:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] red;
      logic signed [31:0] green;
      logic signed [31:0] blue;
   } rgb_type;

   typedef enum logic [2:0] {
      REG_LUT_SIZE,
      REG_MIN_RED,
      REG_MIN_GREEN,
      REG_MIN_BLUE,
      REG_SCALE_RED,
      REG_SCALE_GREEN,
      REG_SCALE_BLUE
   } reg_index_type;

   localparam logic [16:0] ONE_Q16        = 17'h10000;
   localparam logic [5:0]  LUT_SIZE_RESET = 6'd33;
   localparam logic [31:0] SCALE_RESET    = 32'd2097152;

endpackage

// ===== rtl/lti_coord.sv =====
// -----------------------------------------------------------------------------
// lti_coord
// Three-stage offset, scale and clamp of one channel into lattice units.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lti_coord #(
   parameter int CW = 6
) (
   input  logic                clock,
   input  logic [2:0]          stage_en,
   input  logic signed [31:0]  chan,
   input  logic signed [31:0]  origin,
   input  logic [31:0]         scale,
   input  logic [CW+15:0]      top,
   output logic [CW+15:0]      coord
);

   logic signed [32:0] diff_in, diff_ff;
   logic [63:0]        prod_in, prod_ff;
   logic [63:0]        raw_prod;
   logic [47:0]        q;
   logic [CW+15:0]     coord_in, coord_ff;

   assign diff_in  = {chan[31], chan} - {origin[31], origin};
   assign raw_prod = diff_ff[31:0] * scale;
   assign prod_in  = (!diff_ff[32] && (diff_ff != 33'sd0)) ? raw_prod : 64'd0;
   assign q        = prod_ff[63:16];
   assign coord_in = (q > 48'(top)) ? top : q[CW+15:0];
   assign coord    = coord_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         diff_ff <= diff_in;
      end
      if (stage_en[1]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[2]) begin
         coord_ff <= coord_in;
      end
   end

endmodule

// ===== rtl/lti_lattice.sv =====
// -----------------------------------------------------------------------------
// lti_lattice
// Four copies of the lattice memory: one shared write, four registered reads.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lti_lattice
   import lti_pkg::*;
#(
   parameter int DEPTH = 35937,
   parameter int AW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rgb_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr [4],
   output rgb_type       rd_data [4]
);

   for (genvar g = 0; g < 4; g++) begin : g_copy
      rgb_type mem [DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_data[g] <= mem[rd_addr[g]];
         end
      end
   end

endmodule

// ===== rtl/lut3d_tetrahedral_interp_top.sv =====
// -----------------------------------------------------------------------------
// lut3d_tetrahedral_interp_top
// 3D color LUT with tetrahedral interpolation, eight-stage pipeline.
// -----------------------------------------------------------------------------
// The block takes one request per clock when the response side does not stall
// and presents the response to a pixel request from its last stage. Table
// writes travel the same pipeline and update the lattice at the memory stage,
// so they take effect in request order and produce no response. The lattice
// is held in four memory copies so the four corners of a tetrahedron are read
// in the same cycle. The lattice is undefined until written. The user must
// write configuration only while the pipeline is empty, which is not enforced.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lut3d_tetrahedral_interp_top
   import lti_pkg::*;
#(
   parameter int MAX_CUBE_SIZE = 33
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW    = $clog2(MAX_CUBE_SIZE);
   localparam int SW    = $clog2(MAX_CUBE_SIZE + 1);
   localparam int CRW   = CW + 16;
   localparam int DEPTH = MAX_CUBE_SIZE * MAX_CUBE_SIZE * MAX_CUBE_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = (AW > 16) ? AW : 16;
   localparam int IW    = CW + 2 * SW + 1;

   // Configuration registers.
   logic [5:0]         lut_size_ff;
   logic signed [31:0] dmin_ff [3];
   logic [31:0]        scale_ff [3];
   logic               csr_write;
   reg_index_type      csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lut_size_ff <= LUT_SIZE_RESET;
         for (int c = 0; c < 3; c++) begin
            dmin_ff[c]  <= 32'sd0;
            scale_ff[c] <= SCALE_RESET;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LUT_SIZE:    lut_size_ff <= pwdata[5:0];
            REG_MIN_RED:     dmin_ff[0]  <= pwdata;
            REG_MIN_GREEN:   dmin_ff[1]  <= pwdata;
            REG_MIN_BLUE:    dmin_ff[2]  <= pwdata;
            REG_SCALE_RED:   scale_ff[0] <= pwdata;
            REG_SCALE_GREEN: scale_ff[1] <= pwdata;
            REG_SCALE_BLUE:  scale_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LUT_SIZE:    prdata = 32'(lut_size_ff);
         REG_MIN_RED:     prdata = dmin_ff[0];
         REG_MIN_GREEN:   prdata = dmin_ff[1];
         REG_MIN_BLUE:    prdata = dmin_ff[2];
         REG_SCALE_RED:   prdata = scale_ff[0];
         REG_SCALE_GREEN: prdata = scale_ff[1];
         REG_SCALE_BLUE:  prdata = scale_ff[2];
         default:         prdata = 32'd0;
      endcase
   end

   // Effective lattice size and its powers.
   logic [7:0]      lut8;
   logic [7:0]      size_sel;
   logic [SW-1:0]   size_ff;
   logic [2*SW-1:0] sq_ff;
   logic [3*SW-1:0] cube_ff;
   logic [SW-1:0]   size_m1;
   logic [CRW-1:0]  top;

   assign lut8     = {2'b00, lut_size_ff};
   assign size_sel = (lut8 < 8'd2) ? 8'd2 :
                     (lut8 > 8'(MAX_CUBE_SIZE)) ? 8'(MAX_CUBE_SIZE) : lut8;
   assign size_m1  = size_ff - 1'b1;
   assign top      = {size_m1[CW-1:0], 16'h0000};

   always_ff @(posedge clock) begin
      size_ff <= SW'(size_sel);
      sq_ff   <= size_ff * size_ff;
      cube_ff <= sq_ff * size_ff;
   end

   // Stage valids and enables.
   logic [8:1] v_ff;
   logic [8:1] vin;
   logic [8:1] en;
   logic       op_s6_ff;

   always_comb begin
      en[8] = !v_ff[8] || !rsp_stall;
      for (int k = 7; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      vin[1] = req_valid;
      for (int k = 2; k <= 8; k++) begin
         vin[k] = v_ff[k-1];
      end
      vin[7] = v_ff[6] && !op_s6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= 8; k++) begin
            if (en[k]) begin
               v_ff[k] <= vin[k];
            end
         end
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = v_ff[8];

   // Stages 1 to 3: coordinates.
   req_type        req_s1_ff, req_s2_ff, req_s3_ff;
   logic [CRW-1:0] coord [3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         req_s1_ff <= req_data;
      end
      if (en[2]) begin
         req_s2_ff <= req_s1_ff;
      end
      if (en[3]) begin
         req_s3_ff <= req_s2_ff;
      end
   end

   lti_coord #(.CW(CW)) u_coord_red (
      .clock(clock), .stage_en(en[3:1]), .chan(req_data.red_in),
      .origin(dmin_ff[0]), .scale(scale_ff[0]), .top(top), .coord(coord[0])
   );
   lti_coord #(.CW(CW)) u_coord_green (
      .clock(clock), .stage_en(en[3:1]), .chan(req_data.green_in),
      .origin(dmin_ff[1]), .scale(scale_ff[1]), .top(top), .coord(coord[1])
   );
   lti_coord #(.CW(CW)) u_coord_blue (
      .clock(clock), .stage_en(en[3:1]), .chan(req_data.blue_in),
      .origin(dmin_ff[2]), .scale(scale_ff[2]), .top(top), .coord(coord[2])
   );

   // Stage 4: tetrahedron selection and weights.
   logic [CW-1:0] x0, y0, z0, x1, y1, z1;
   logic [16:0]   dx, dy, dz;
   logic [CW-1:0] pr_in [4], pg_in [4], pb_in [4];
   logic [16:0]   w_in [4];
   logic [CW-1:0] pr_ff [4], pg_ff [4], pb_ff [4];
   logic [16:0]   w_s4_ff [4], w_s5_ff [4], w_s6_ff [4];
   req_type       req_s4_ff;

   always_comb begin
      x0 = coord[0][CRW-1:16];
      y0 = coord[1][CRW-1:16];
      z0 = coord[2][CRW-1:16];
      dx = {1'b0, coord[0][15:0]};
      dy = {1'b0, coord[1][15:0]};
      dz = {1'b0, coord[2][15:0]};
      x1 = (SW'(x0) < size_m1) ? CW'(x0 + 1'b1) : x0;
      y1 = (SW'(y0) < size_m1) ? CW'(y0 + 1'b1) : y0;
      z1 = (SW'(z0) < size_m1) ? CW'(z0 + 1'b1) : z0;
      pr_in[0] = x0; pg_in[0] = y0; pb_in[0] = z0;
      pr_in[3] = x1; pg_in[3] = y1; pb_in[3] = z1;
      if (dx >= dy) begin
         if (dy >= dz) begin
            w_in[0] = ONE_Q16 - dx; w_in[1] = dx - dy; w_in[2] = dy - dz; w_in[3] = dz;
            pr_in[1] = x1; pg_in[1] = y0; pb_in[1] = z0;
            pr_in[2] = x1; pg_in[2] = y1; pb_in[2] = z0;
         end else if (dx >= dz) begin
            w_in[0] = ONE_Q16 - dx; w_in[1] = dx - dz; w_in[2] = dz - dy; w_in[3] = dy;
            pr_in[1] = x1; pg_in[1] = y0; pb_in[1] = z0;
            pr_in[2] = x1; pg_in[2] = y0; pb_in[2] = z1;
         end else begin
            w_in[0] = ONE_Q16 - dz; w_in[1] = dz - dx; w_in[2] = dx - dy; w_in[3] = dy;
            pr_in[1] = x0; pg_in[1] = y0; pb_in[1] = z1;
            pr_in[2] = x1; pg_in[2] = y0; pb_in[2] = z1;
         end
      end else begin
         if (dz >= dy) begin
            w_in[0] = ONE_Q16 - dz; w_in[1] = dz - dy; w_in[2] = dy - dx; w_in[3] = dx;
            pr_in[1] = x0; pg_in[1] = y0; pb_in[1] = z1;
            pr_in[2] = x0; pg_in[2] = y1; pb_in[2] = z1;
         end else if (dz >= dx) begin
            w_in[0] = ONE_Q16 - dy; w_in[1] = dy - dz; w_in[2] = dz - dx; w_in[3] = dx;
            pr_in[1] = x0; pg_in[1] = y1; pb_in[1] = z0;
            pr_in[2] = x0; pg_in[2] = y1; pb_in[2] = z1;
         end else begin
            w_in[0] = ONE_Q16 - dy; w_in[1] = dy - dx; w_in[2] = dx - dz; w_in[3] = dz;
            pr_in[1] = x0; pg_in[1] = y1; pb_in[1] = z0;
            pr_in[2] = x1; pg_in[2] = y1; pb_in[2] = z0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         req_s4_ff <= req_s3_ff;
         pr_ff     <= pr_in;
         pg_ff     <= pg_in;
         pb_ff     <= pb_in;
         w_s4_ff   <= w_in;
      end
   end

   // Stage 5: lattice addresses and write qualification.
   logic [AW-1:0] idx_in [4];
   logic [AW-1:0] idx_ff [4];
   logic          wr_ok_in, wr_ok_ff, op_s5_ff;
   logic [AW-1:0] wr_addr_ff;
   rgb_type       wr_data_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         idx_in[i] = AW'(IW'(pr_ff[i]) + IW'(pg_ff[i]) * IW'(size_ff)
                       + IW'(pb_ff[i]) * IW'(sq_ff));
      end
      wr_ok_in = req_s4_ff.operation && (EW'(req_s4_ff.entry_index) < EW'(cube_ff));
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         idx_ff     <= idx_in;
         wr_ok_ff   <= wr_ok_in;
         op_s5_ff   <= req_s4_ff.operation;
         wr_addr_ff <= AW'(req_s4_ff.entry_index);
         wr_data_ff <= {req_s4_ff.red_in, req_s4_ff.green_in, req_s4_ff.blue_in};
         w_s5_ff    <= w_s4_ff;
      end
   end

   // Stage 6: lattice read and table write.
   rgb_type lat_q [4];

   lti_lattice #(.DEPTH(DEPTH), .AW(AW)) u_lattice (
      .clock   (clock),
      .wr_en   (en[6] && v_ff[5] && wr_ok_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .rd_en   (en[6]),
      .rd_addr (idx_ff),
      .rd_data (lat_q)
   );

   always_ff @(posedge clock) begin
      if (en[6]) begin
         op_s6_ff <= op_s5_ff;
         w_s6_ff  <= w_s5_ff;
      end
   end

   // Stage 7: weighted corners.
   logic signed [49:0] prod_in [3][4];
   logic signed [49:0] prod_ff [3][4];
   logic signed [17:0] ws [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ws[i]         = $signed({1'b0, w_s6_ff[i]});
         prod_in[0][i] = lat_q[i].red * ws[i];
         prod_in[1][i] = lat_q[i].green * ws[i];
         prod_in[2][i] = lat_q[i].blue * ws[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 8: sum and round to nearest.
   logic signed [51:0] acc [3];
   rsp_type            rsp_in, rsp_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = 52'(prod_ff[c][0]) + 52'(prod_ff[c][1]) + 52'(prod_ff[c][2])
                + 52'(prod_ff[c][3]) + 52'sd32768;
      end
      rsp_in.red_out   = acc[0][47:16];
      rsp_in.green_out = acc[1][47:16];
      rsp_in.blue_out  = acc[2][47:16];
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   `ASSERT_IMPLY(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ASSERT_IMPLY(a_weights_sum_to_one, clock, reset, v_ff[5], (18'(w_s5_ff[0]) + 18'(w_s5_ff[1]) + 18'(w_s5_ff[2]) + 18'(w_s5_ff[3])) == 18'(ONE_Q16))
   `ASSERT_IMPLY(a_size_in_range, clock, reset, v_ff[4], (size_ff >= SW'(2)) && (size_ff <= SW'(MAX_CUBE_SIZE)))
   `ASSERT_NEXT(a_pixel_reaches_output, clock, reset, v_ff[7] && en[8], rsp_valid)

endmodule
